### rtl/core/bltc_pkg.sv
// Shared constants for the blit rectangle clipper: defaults, register indexes, command kinds.
package bltc_pkg;

  localparam int COORD_BITS_DEF = 16;

  // Configuration register indexes
  localparam int CFG_INDEX_BITS = 3;
  localparam logic [CFG_INDEX_BITS-1:0] REG_SCREEN_MAX_X     = 3'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_SCREEN_MAX_Y     = 3'd1;
  localparam logic [CFG_INDEX_BITS-1:0] REG_USER_CLIP_ENABLE = 3'd2;
  localparam logic [CFG_INDEX_BITS-1:0] REG_USER_CLIP_X0     = 3'd3;
  localparam logic [CFG_INDEX_BITS-1:0] REG_USER_CLIP_Y0     = 3'd4;
  localparam logic [CFG_INDEX_BITS-1:0] REG_USER_CLIP_X1     = 3'd5;
  localparam logic [CFG_INDEX_BITS-1:0] REG_USER_CLIP_Y1     = 3'd6;

  // Register reset values
  localparam int SCREEN_MAX_X_RST = 639;
  localparam int SCREEN_MAX_Y_RST = 479;

  // Command kinds
  localparam logic KIND_COPY = 1'b0;
  localparam logic KIND_FILL = 1'b1;

endpackage

### rtl/core/bltc_if.sv
// Command and result channel interfaces of the blit rectangle clipper.
interface bltc_cmd_if
  import bltc_pkg::*;
#(
  parameter int W = COORD_BITS_DEF
);
  logic                valid;
  logic                ready;
  logic                kind;
  logic signed [W-1:0] rect_x0;
  logic signed [W-1:0] rect_y0;
  logic signed [W-1:0] rect_x1;
  logic signed [W-1:0] rect_y1;
  logic signed [W-1:0] dest_x;
  logic signed [W-1:0] dest_y;

  modport source (
    output valid, kind, rect_x0, rect_y0, rect_x1, rect_y1, dest_x, dest_y,
    input  ready
  );
  modport sink (
    input  valid, kind, rect_x0, rect_y0, rect_x1, rect_y1, dest_x, dest_y,
    output ready
  );
endinterface

interface bltc_res_if
  import bltc_pkg::*;
#(
  parameter int W = COORD_BITS_DEF
);
  logic                valid;
  logic                ready;
  logic                visible;
  logic signed [W-1:0] src_left;
  logic signed [W-1:0] src_top;
  logic signed [W-1:0] src_right;
  logic signed [W-1:0] src_bottom;
  logic signed [W-1:0] dst_left;
  logic signed [W-1:0] dst_top;
  logic signed [W-1:0] dst_right;
  logic signed [W-1:0] dst_bottom;

  modport source (
    output valid, visible, src_left, src_top, src_right, src_bottom,
           dst_left, dst_top, dst_right, dst_bottom,
    input  ready
  );
  modport sink (
    input  valid, visible, src_left, src_top, src_right, src_bottom,
           dst_left, dst_top, dst_right, dst_bottom,
    output ready
  );
endinterface

### rtl/core/bltc_window.sv
// Configuration registers and the registered clip window they define.
module bltc_window
  import bltc_pkg::*;
#(
  parameter int W = COORD_BITS_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_we,
  input  logic [CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [W-1:0]              cfg_data,
  output logic signed [W-1:0]       cx0,
  output logic signed [W-1:0]       cy0,
  output logic signed [W-1:0]       cx1,
  output logic signed [W-1:0]       cy1
);

  logic [W-2:0]        screen_max_x;
  logic [W-2:0]        screen_max_y;
  logic                user_clip_enable;
  logic signed [W-1:0] user_clip_x0;
  logic signed [W-1:0] user_clip_y0;
  logic signed [W-1:0] user_clip_x1;
  logic signed [W-1:0] user_clip_y1;

  logic signed [W-1:0] smx, smy, ux_lo, ux_hi, uy_lo, uy_hi;
  logic signed [W-1:0] cx0_next, cy0_next, cx1_next, cy1_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      screen_max_x     <= (W-1)'(SCREEN_MAX_X_RST);
      screen_max_y     <= (W-1)'(SCREEN_MAX_Y_RST);
      user_clip_enable <= 1'b0;
      user_clip_x0     <= '0;
      user_clip_y0     <= '0;
      user_clip_x1     <= '0;
      user_clip_y1     <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_SCREEN_MAX_X:     screen_max_x     <= cfg_data[W-2:0];
        REG_SCREEN_MAX_Y:     screen_max_y     <= cfg_data[W-2:0];
        REG_USER_CLIP_ENABLE: user_clip_enable <= cfg_data[0];
        REG_USER_CLIP_X0:     user_clip_x0     <= cfg_data;
        REG_USER_CLIP_Y0:     user_clip_y0     <= cfg_data;
        REG_USER_CLIP_X1:     user_clip_x1     <= cfg_data;
        REG_USER_CLIP_Y1:     user_clip_y1     <= cfg_data;
        default: ;
      endcase
    end
  end

  // Sort the user corners, then intersect with the screen
  always_comb begin
    smx   = {1'b0, screen_max_x};
    smy   = {1'b0, screen_max_y};
    ux_lo = (user_clip_x0 < user_clip_x1) ? user_clip_x0 : user_clip_x1;
    ux_hi = (user_clip_x0 > user_clip_x1) ? user_clip_x0 : user_clip_x1;
    uy_lo = (user_clip_y0 < user_clip_y1) ? user_clip_y0 : user_clip_y1;
    uy_hi = (user_clip_y0 > user_clip_y1) ? user_clip_y0 : user_clip_y1;
    cx0_next = '0;
    cy0_next = '0;
    cx1_next = smx;
    cy1_next = smy;
    if (user_clip_enable) begin
      if (!ux_lo[W-1]) cx0_next = ux_lo;
      if (!uy_lo[W-1]) cy0_next = uy_lo;
      if (ux_hi < smx) cx1_next = ux_hi;
      if (uy_hi < smy) cy1_next = uy_hi;
    end
  end

  // Registered window; users (unchecked) move it only with pipeline empty
  always_ff @(posedge clk) begin
    cx0 <= cx0_next;
    cy0 <= cy0_next;
    cx1 <= cx1_next;
    cy1 <= cy1_next;
  end

endmodule

### rtl/core/blit_rectangle_clipper.sv
// Blit rectangle clipper: eight-stage pipeline that clips copy and fill commands.
// Each accepted item moves through the stage registers, then the output register.
// Throughput: one item per cycle; the whole pipeline holds when the result is stalled.
// A configuration write takes effect for items accepted from the following cycle on.
// Reset (rst, synchronous) empties the pipeline and loads the registers with
// screen 639 x 479 and the user clip rectangle off and zero.
module blit_rectangle_clipper
  import bltc_pkg::*;
#(
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  bltc_cmd_if.sink                  cmd,
  bltc_res_if.source                res,
  input  logic                      cfg_we,
  input  logic [CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [COORD_BITS-1:0]     cfg_data
);

  localparam int W  = COORD_BITS;
  // Internal width: exact sums of offsets and extents never wrap here
  localparam int E  = W + 3;
  localparam int NS = 7;

  typedef struct {
    logic                kind;
    logic                vis;
    logic signed [E-1:0] sl, st, sr, sb;
    logic signed [E-1:0] dl, dt, dr, db;
    logic signed [E-1:0] e0, e1, e2, e3;
  } stage_t;

  typedef struct {
    logic                visible;
    logic signed [W-1:0] src_left, src_top, src_right, src_bottom;
    logic signed [W-1:0] dst_left, dst_top, dst_right, dst_bottom;
  } res_t;

  function automatic logic signed [E-1:0] sx(input logic [W-1:0] v);
    return {{(E-W){v[W-1]}}, v};
  endfunction

  function automatic logic signed [E-1:0] smin(input logic signed [E-1:0] a,
                                               input logic signed [E-1:0] b);
    return (a < b) ? a : b;
  endfunction

  function automatic logic signed [E-1:0] smax(input logic signed [E-1:0] a,
                                               input logic signed [E-1:0] b);
    return (a > b) ? a : b;
  endfunction

  // Strictly positive: not negative and not zero
  function automatic logic pos(input logic signed [E-1:0] v);
    return !v[E-1] && (v != '0);
  endfunction

  logic signed [W-1:0] cx0, cy0, cx1, cy1;
  logic signed [E-1:0] cx0e, cy0e, cx1e, cy1e;

  stage_t       stg [1:NS];
  stage_t       nxt [1:NS];
  logic [NS:1]  vld;
  res_t         res_q;
  res_t         res_next;
  logic         res_vld;
  logic         en;

  // Clip window from the configuration registers
  bltc_window #(.W(W)) u_window (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cx0       (cx0),
    .cy0       (cy0),
    .cx1       (cx1),
    .cy1       (cy1)
  );

  assign cx0e = sx(cx0);
  assign cy0e = sx(cy0);
  assign cx1e = sx(cx1);
  assign cy1e = sx(cy1);

  // Advance every stage together whenever the output register can take an item
  assign en        = !res_vld || res.ready;
  assign cmd.ready = en;

  // Stage 1: sort the rectangle corners, widen the destination origin
  always_comb begin
    nxt[1]      = '{default: '0};
    nxt[1].kind = cmd.kind;
    nxt[1].vis  = 1'b1;
    nxt[1].sl   = smin(sx(cmd.rect_x0), sx(cmd.rect_x1));
    nxt[1].sr   = smax(sx(cmd.rect_x0), sx(cmd.rect_x1));
    nxt[1].st   = smin(sx(cmd.rect_y0), sx(cmd.rect_y1));
    nxt[1].sb   = smax(sx(cmd.rect_y0), sx(cmd.rect_y1));
    nxt[1].dl   = sx(cmd.dest_x);
    nxt[1].dt   = sx(cmd.dest_y);
  end

  // Stage 2: reject a source fully outside; a fill is finished here,
  // a copy takes its extents
  always_comb begin
    nxt[2]     = stg[1];
    nxt[2].vis = !(stg[1].sl > cx1e || stg[1].sr < cx0e ||
                   stg[1].st > cy1e || stg[1].sb < cy0e);
    if (stg[1].kind == KIND_FILL) begin
      nxt[2].dl = smax(stg[1].sl, cx0e);
      nxt[2].dr = smin(stg[1].sr, cx1e);
      nxt[2].dt = smax(stg[1].st, cy0e);
      nxt[2].db = smin(stg[1].sb, cy1e);
      nxt[2].sl = nxt[2].dl;
      nxt[2].sr = nxt[2].dr;
      nxt[2].st = nxt[2].dt;
      nxt[2].sb = nxt[2].db;
    end else begin
      nxt[2].dr = stg[1].sr - stg[1].sl;
      nxt[2].db = stg[1].sb - stg[1].st;
    end
  end

  // Stage 3: place the destination's far corner
  always_comb begin
    nxt[3] = stg[2];
    if (stg[2].kind == KIND_COPY) begin
      nxt[3].dr = stg[2].dl + stg[2].dr;
      nxt[3].db = stg[2].dt + stg[2].db;
    end
  end

  // Stage 4: reject a destination fully outside; measure source overhang
  always_comb begin
    nxt[4] = stg[3];
    if (stg[3].kind == KIND_COPY) begin
      nxt[4].vis = stg[3].vis &&
                   !(stg[3].dl > cx1e || stg[3].dt > cy1e ||
                     stg[3].dr < cx0e || stg[3].db < cy0e);
      nxt[4].e0 = cx0e - stg[3].sl;
      nxt[4].e1 = cy0e - stg[3].st;
      nxt[4].e2 = stg[3].sr - cx1e;
      nxt[4].e3 = stg[3].sb - cy1e;
    end
  end

  // Stage 5: trim both rectangles where the source leaves the window
  always_comb begin
    nxt[5] = stg[4];
    if (stg[4].kind == KIND_COPY) begin
      if (pos(stg[4].e0)) begin
        nxt[5].dl = stg[4].dl + stg[4].e0;
        nxt[5].sl = cx0e;
      end
      if (pos(stg[4].e1)) begin
        nxt[5].dt = stg[4].dt + stg[4].e1;
        nxt[5].st = cy0e;
      end
      if (pos(stg[4].e2)) begin
        nxt[5].dr = stg[4].dr - stg[4].e2;
        nxt[5].sr = cx1e;
      end
      if (pos(stg[4].e3)) begin
        nxt[5].db = stg[4].db - stg[4].e3;
        nxt[5].sb = cy1e;
      end
    end
  end

  // Stage 6: measure destination overhang
  always_comb begin
    nxt[6] = stg[5];
    if (stg[5].kind == KIND_COPY) begin
      nxt[6].e0 = cx0e - stg[5].dl;
      nxt[6].e1 = cy0e - stg[5].dt;
      nxt[6].e2 = stg[5].dr - cx1e;
      nxt[6].e3 = stg[5].db - cy1e;
    end
  end

  // Stage 7: trim both rectangles where the destination leaves the window
  always_comb begin
    nxt[7] = stg[6];
    if (stg[6].kind == KIND_COPY) begin
      if (pos(stg[6].e0)) begin
        nxt[7].sl = stg[6].sl + stg[6].e0;
        nxt[7].dl = cx0e;
      end
      if (pos(stg[6].e1)) begin
        nxt[7].st = stg[6].st + stg[6].e1;
        nxt[7].dt = cy0e;
      end
      if (pos(stg[6].e2)) begin
        nxt[7].sr = stg[6].sr - stg[6].e2;
        nxt[7].dr = cx1e;
      end
      if (pos(stg[6].e3)) begin
        nxt[7].sb = stg[6].sb - stg[6].e3;
        nxt[7].db = cy1e;
      end
    end
  end

  // Stage 8: mark empty results invisible, zero every field of an invisible one
  always_comb begin
    res_next.visible = stg[7].vis && !(stg[7].dr < stg[7].dl || stg[7].db < stg[7].dt);
    res_next.src_left   = '0;
    res_next.src_top    = '0;
    res_next.src_right  = '0;
    res_next.src_bottom = '0;
    res_next.dst_left   = '0;
    res_next.dst_top    = '0;
    res_next.dst_right  = '0;
    res_next.dst_bottom = '0;
    if (res_next.visible) begin
      res_next.src_left   = stg[7].sl[W-1:0];
      res_next.src_top    = stg[7].st[W-1:0];
      res_next.src_right  = stg[7].sr[W-1:0];
      res_next.src_bottom = stg[7].sb[W-1:0];
      res_next.dst_left   = stg[7].dl[W-1:0];
      res_next.dst_top    = stg[7].dt[W-1:0];
      res_next.dst_right  = stg[7].dr[W-1:0];
      res_next.dst_bottom = stg[7].db[W-1:0];
    end
  end

  // Valid bits travel with the data
  always_ff @(posedge clk) begin
    if (rst) begin
      vld     <= '0;
      res_vld <= 1'b0;
    end else if (en) begin
      vld[1] <= cmd.valid;
      for (int k = 2; k <= NS; k++) begin
        vld[k] <= vld[k-1];
      end
      res_vld <= vld[NS];
    end
  end

  // Payload registers, held while the output is stalled
  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 1; k <= NS; k++) begin
        stg[k] <= nxt[k];
      end
      res_q <= res_next;
    end
  end

  assign res.valid      = res_vld;
  assign res.visible    = res_q.visible;
  assign res.src_left   = res_q.src_left;
  assign res.src_top    = res_q.src_top;
  assign res.src_right  = res_q.src_right;
  assign res.src_bottom = res_q.src_bottom;
  assign res.dst_left   = res_q.dst_left;
  assign res.dst_top    = res_q.dst_top;
  assign res.dst_right  = res_q.dst_right;
  assign res.dst_bottom = res_q.dst_bottom;

endmodule

### verif/tb_blit_rectangle_clipper.sv
// Self-checking testbench for the blit rectangle clipper: directed table, then random commands.
`timescale 1ns / 1ps

module tb_blit_rectangle_clipper;
  import bltc_pkg::*;

  localparam int W = COORD_BITS_DEF;
  // Pipeline latency; used for the drain pauses only.
  localparam int LATENCY = 7;
  // Cycles without any handshake before the run is declared hung.
  localparam int STUCK_LIMIT = 5000;
  // Index with no register behind it; writes there must change nothing.
  localparam logic [CFG_INDEX_BITS-1:0] REG_UNUSED = 3'd7;

  localparam logic signed [W-1:0] CMIN = 16'sh8000;
  localparam logic signed [W-1:0] CMAX = 16'sh7FFF;

  typedef struct packed {
    logic                kind;
    logic signed [W-1:0] x0;
    logic signed [W-1:0] y0;
    logic signed [W-1:0] x1;
    logic signed [W-1:0] y1;
    logic signed [W-1:0] dest_x;
    logic signed [W-1:0] dest_y;
  } cmd_item_t;

  typedef struct packed {
    logic                visible;
    logic signed [W-1:0] src_left;
    logic signed [W-1:0] src_top;
    logic signed [W-1:0] src_right;
    logic signed [W-1:0] src_bottom;
    logic signed [W-1:0] dst_left;
    logic signed [W-1:0] dst_top;
    logic signed [W-1:0] dst_right;
    logic signed [W-1:0] dst_bottom;
  } res_item_t;

  // One row of the directed table: the command, and a hand-written result
  // where 'typed' is set (otherwise the predictor supplies it).
  typedef struct packed {
    cmd_item_t c;
    logic      typed;
    res_item_t r;
  } dir_row_t;

  // Rejected commands come back with every rectangle field cleared.
  localparam res_item_t CLIP_NONE = '0;
  // Whole 640 x 480 screen, as source and destination.
  localparam res_item_t FULL_SCREEN = '{1'b1, 16'sd0, 16'sd0, 16'sd639, 16'sd479,
                                        16'sd0, 16'sd0, 16'sd639, 16'sd479};

  // Directed commands, all run with the reset window: columns 0..639, rows 0..479.
  dir_row_t dir_rows [20] = '{
    // fill covering the screen exactly, then with corners swapped
    '{'{KIND_FILL, 16'sd0, 16'sd0, 16'sd639, 16'sd479, 16'sd0, 16'sd0}, 1'b1, FULL_SCREEN},
    '{'{KIND_FILL, 16'sd639, 16'sd479, 16'sd0, 16'sd0, 16'sd0, 16'sd0}, 1'b1, FULL_SCREEN},
    // fill spanning the whole coordinate range clips to the screen
    '{'{KIND_FILL, CMIN, CMIN, CMAX, CMAX, 16'sd0, 16'sd0}, 1'b1, FULL_SCREEN},
    // fills fully left, right and below the screen are empty
    '{'{KIND_FILL, CMIN, 16'sd0, -16'sd1, 16'sd10, 16'sd0, 16'sd0}, 1'b1, CLIP_NONE},
    '{'{KIND_FILL, 16'sd640, 16'sd0, CMAX, 16'sd479, 16'sd0, 16'sd0}, 1'b1, CLIP_NONE},
    '{'{KIND_FILL, 16'sd0, 16'sd480, 16'sd639, CMAX, 16'sd0, 16'sd0}, 1'b1, CLIP_NONE},
    // single pixel in the far corner
    '{'{KIND_FILL, 16'sd639, 16'sd479, 16'sd639, 16'sd479, 16'sd0, 16'sd0}, 1'b1,
      '{1'b1, 16'sd639, 16'sd479, 16'sd639, 16'sd479, 16'sd639, 16'sd479, 16'sd639, 16'sd479}},
    // fill with garbage in the destination fields, which it must ignore
    '{'{KIND_FILL, 16'sd100, 16'sd50, -16'sd20, -16'sd30, CMIN, CMAX}, 1'b0, CLIP_NONE},
    // copy fully inside, corners in both orders
    '{'{KIND_COPY, 16'sd10, 16'sd20, 16'sd110, 16'sd70, 16'sd200, 16'sd300}, 1'b1,
      '{1'b1, 16'sd10, 16'sd20, 16'sd110, 16'sd70, 16'sd200, 16'sd300, 16'sd300, 16'sd350}},
    '{'{KIND_COPY, 16'sd110, 16'sd70, 16'sd10, 16'sd20, 16'sd200, 16'sd300}, 1'b1,
      '{1'b1, 16'sd10, 16'sd20, 16'sd110, 16'sd70, 16'sd200, 16'sd300, 16'sd300, 16'sd350}},
    // source off screen, destination off screen, destination at both extremes
    '{'{KIND_COPY, -16'sd100, -16'sd100, -16'sd1, -16'sd1, 16'sd0, 16'sd0}, 1'b1, CLIP_NONE},
    '{'{KIND_COPY, 16'sd0, 16'sd0, 16'sd10, 16'sd10, 16'sd640, 16'sd0}, 1'b1, CLIP_NONE},
    '{'{KIND_COPY, 16'sd0, 16'sd0, 16'sd639, 16'sd479, CMIN, CMIN}, 1'b1, CLIP_NONE},
    '{'{KIND_COPY, 16'sd0, 16'sd0, 16'sd5, 16'sd5, CMAX, CMAX}, 1'b1, CLIP_NONE},
    // full-range source: sizes exceed 16 bits, so sums must not wrap
    '{'{KIND_COPY, CMIN, CMIN, CMAX, CMAX, CMIN, CMIN}, 1'b0, CLIP_NONE},
    '{'{KIND_COPY, CMAX, CMAX, CMIN, CMIN, 16'sd0, 16'sd0}, 1'b0, CLIP_NONE},
    // trims on both sides: source leaves left, destination leaves right / top-left
    '{'{KIND_COPY, -16'sd10, 16'sd0, 16'sd100, 16'sd50, 16'sd600, 16'sd100}, 1'b0, CLIP_NONE},
    '{'{KIND_COPY, 16'sd100, 16'sd100, 16'sd200, 16'sd200, -16'sd50, -16'sd20}, 1'b0, CLIP_NONE},
    // all-ones coordinates, then a one-pixel copy into the far corner
    '{'{KIND_COPY, -16'sd1, -16'sd1, -16'sd1, -16'sd1, -16'sd1, -16'sd1}, 1'b1, CLIP_NONE},
    '{'{KIND_COPY, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd639, 16'sd479}, 1'b1,
      '{1'b1, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd639, 16'sd479, 16'sd639, 16'sd479}}
  };

  logic                      clk;
  logic                      rst;
  logic                      cfg_we;
  logic [CFG_INDEX_BITS-1:0] cfg_index;
  logic [W-1:0]              cfg_data;

  bltc_cmd_if #(.W(W)) cmd ();
  bltc_res_if #(.W(W)) res ();

  blit_rectangle_clipper #(.COORD_BITS(W)) i_dut (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .res       (res),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // Shadow of the clip registers as the predictor sees them.
  logic [W-2:0]        max_col;
  logic [W-2:0]        max_row;
  logic                clip_on;
  logic signed [W-1:0] clip_x0;
  logic signed [W-1:0] clip_y0;
  logic signed [W-1:0] clip_x1;
  logic signed [W-1:0] clip_y1;

  // Clipped results owed by the block, oldest first.
  res_item_t expected_clips [$];

  // Set for stretches where neither side is allowed to idle.
  bit no_idle = 1'b0;
  int hold_cycles = 0;
  int stuck_cycles = 0;

  int n_errors = 0;
  int n_items = 0;
  int n_copies = 0;
  int n_visible = 0;
  int n_settings = 0;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic longint lmin(input longint a, input longint b);
    return (a < b) ? a : b;
  endfunction

  function automatic longint lmax(input longint a, input longint b);
    return (a > b) ? a : b;
  endfunction

  // Track a register write the same way the block keeps it: low bits only,
  // unknown indexes dropped.
  function automatic void apply_reg(input logic [CFG_INDEX_BITS-1:0] idx,
                                    input logic [W-1:0] data);
    case (idx)
      REG_SCREEN_MAX_X:     max_col = data[W-2:0];
      REG_SCREEN_MAX_Y:     max_row = data[W-2:0];
      REG_USER_CLIP_ENABLE: clip_on = data[0];
      REG_USER_CLIP_X0:     clip_x0 = data;
      REG_USER_CLIP_Y0:     clip_y0 = data;
      REG_USER_CLIP_X1:     clip_x1 = data;
      REG_USER_CLIP_Y1:     clip_y1 = data;
      default: ;
    endcase
  endfunction

  // Predict the clipped result of one command. All arithmetic is done in
  // 64 bits so that sizes and offsets never wrap.
  function automatic res_item_t clip_command(input cmd_item_t c);
    longint wl, wt, wr, wb;
    longint sl, st, sr, sb;
    longint dl, dt, dr, db;
    logic   seen;
    res_item_t r;
    // Window: screen, narrowed by the sorted user rectangle when enabled.
    wl = 0;
    wt = 0;
    wr = longint'(max_col);
    wb = longint'(max_row);
    if (clip_on) begin
      wl = lmax(wl, lmin(clip_x0, clip_x1));
      wr = lmin(wr, lmax(clip_x0, clip_x1));
      wt = lmax(wt, lmin(clip_y0, clip_y1));
      wb = lmin(wb, lmax(clip_y0, clip_y1));
    end
    sl = lmin(c.x0, c.x1);
    sr = lmax(c.x0, c.x1);
    st = lmin(c.y0, c.y1);
    sb = lmax(c.y0, c.y1);
    seen = !(sl > wr || sr < wl || st > wb || sb < wt);
    if (c.kind == KIND_COPY) begin
      dl = c.dest_x;
      dt = c.dest_y;
      dr = dl + (sr - sl);
      db = dt + (sb - st);
      if (seen && (dl > wr || dt > wb || dr < wl || db < wt))
        seen = 1'b0;
      if (seen) begin
        // trim where the source leaves the window, moving the destination along
        if (sl < wl) begin dl += wl - sl; sl = wl; end
        if (st < wt) begin dt += wt - st; st = wt; end
        if (sr > wr) begin dr -= sr - wr; sr = wr; end
        if (sb > wb) begin db -= sb - wb; sb = wb; end
        // then where the destination leaves it, moving the source along
        if (dl < wl) begin sl += wl - dl; dl = wl; end
        if (dt < wt) begin st += wt - dt; dt = wt; end
        if (dr > wr) begin sr -= dr - wr; dr = wr; end
        if (db > wb) begin sb -= db - wb; db = wb; end
        if (dr < dl || db < dt)
          seen = 1'b0;
      end
    end else begin
      dl = lmax(sl, wl);
      dr = lmin(sr, wr);
      dt = lmax(st, wt);
      db = lmin(sb, wb);
      if (dr < dl || db < dt)
        seen = 1'b0;
      sl = dl;
      st = dt;
      sr = dr;
      sb = db;
    end
    r = CLIP_NONE;
    if (seen) begin
      r.visible    = 1'b1;
      r.src_left   = sl[W-1:0];
      r.src_top    = st[W-1:0];
      r.src_right  = sr[W-1:0];
      r.src_bottom = sb[W-1:0];
      r.dst_left   = dl[W-1:0];
      r.dst_top    = dt[W-1:0];
      r.dst_right  = dr[W-1:0];
      r.dst_bottom = db[W-1:0];
    end
    return r;
  endfunction

  // Idle length: mostly none or short, now and then long.
  function automatic int pick_gap();
    int r;
    if (no_idle)
      return 0;
    r = $urandom_range(0, 99);
    if (r < 55)
      return 0;
    if (r < 90)
      return $urandom_range(1, 3);
    if (r < 98)
      return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Coordinate biased toward the window edges, with some extremes and some
  // fully random words so that every bit toggles.
  function automatic logic signed [W-1:0] pick_coord(input int span);
    int          r;
    int          v;
    logic [31:0] u;
    r = $urandom_range(0, 99);
    u = $urandom;
    if (r < 15)
      return u[W-1:0];
    if (r < 25) begin
      case (u[2:0])
        3'd0:    v = -32768;
        3'd1:    v = 32767;
        3'd2:    v = 0;
        3'd3:    v = -1;
        3'd4:    v = span;
        default: v = span + 1;
      endcase
    end else begin
      v = $urandom_range(0, span + 128) - 64;
    end
    if (v > 32767)
      v = 32767;
    return v[W-1:0];
  endfunction

  function automatic cmd_item_t gen_command();
    cmd_item_t c;
    int        sx;
    int        sy;
    sx = int'(max_col);
    sy = int'(max_row);
    c.kind   = $urandom_range(0, 1) ? KIND_FILL : KIND_COPY;
    c.x0     = pick_coord(sx);
    c.y0     = pick_coord(sy);
    c.x1     = pick_coord(sx);
    c.y1     = pick_coord(sy);
    c.dest_x = pick_coord(sx);
    c.dest_y = pick_coord(sy);
    return c;
  endfunction

  function automatic string show_clip(input res_item_t r);
    return $sformatf("vis=%0d src=(%0d,%0d,%0d,%0d) dst=(%0d,%0d,%0d,%0d)",
                     r.visible, r.src_left, r.src_top, r.src_right, r.src_bottom,
                     r.dst_left, r.dst_top, r.dst_right, r.dst_bottom);
  endfunction

  // Offer one command after a random gap and hold it until accepted; record
  // its expected result at the accepting edge.
  task automatic push_cmd(input cmd_item_t c, input logic typed, input res_item_t want);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      cmd.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    cmd.valid   <= 1'b1;
    cmd.kind    <= c.kind;
    cmd.rect_x0 <= c.x0;
    cmd.rect_y0 <= c.y0;
    cmd.rect_x1 <= c.x1;
    cmd.rect_y1 <= c.y1;
    cmd.dest_x  <= c.dest_x;
    cmd.dest_y  <= c.dest_y;
    @(posedge clk);
    while (!cmd.ready) @(posedge clk);
    expected_clips.push_back(typed ? want : clip_command(c));
    n_items++;
    if (c.kind == KIND_COPY)
      n_copies++;
  endtask

  // Drop valid and wait until every owed result is back, then for a margin sized from LATENCY.
  task automatic settle();
    cmd.valid <= 1'b0;
    while (expected_clips.size() != 0) @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] idx, input logic [W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    apply_reg(idx, data);
  endtask

  // Write the whole register set back to back; only call while settled.
  task automatic load_config(input logic [W-1:0] mx, input logic [W-1:0] my,
                             input logic [W-1:0] en,
                             input logic [W-1:0] ux0, input logic [W-1:0] uy0,
                             input logic [W-1:0] ux1, input logic [W-1:0] uy1);
    write_reg(REG_SCREEN_MAX_X, mx);
    write_reg(REG_SCREEN_MAX_Y, my);
    write_reg(REG_USER_CLIP_ENABLE, en);
    write_reg(REG_USER_CLIP_X0, ux0);
    write_reg(REG_USER_CLIP_Y0, uy0);
    write_reg(REG_USER_CLIP_X1, ux1);
    write_reg(REG_USER_CLIP_Y1, uy1);
    cfg_we <= 1'b0;
    n_settings++;
  endtask

  // Random commands under the current setting; optionally hold off halfway
  // until the block has drained completely.
  task automatic run_random(input int count, input logic drain_midway);
    for (int k = 0; k < count; k++) begin
      if (drain_midway && k == count / 2)
        settle();
      push_cmd(gen_command(), 1'b0, CLIP_NONE);
    end
  endtask

  // Result side: ready with random stalls, released during no-idle stretches.
  initial begin
    res.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_cycles == 0 && $urandom_range(0, 3) == 0)
        hold_cycles = pick_gap();
      if (hold_cycles > 0) begin
        res.ready <= 1'b0;
        hold_cycles--;
      end else begin
        res.ready <= 1'b1;
      end
    end
  end

  // Compare each delivered result with the oldest owed one.
  always @(posedge clk) begin
    res_item_t got;
    res_item_t want;
    if (!rst && res.valid && res.ready) begin
      got = '{res.visible, res.src_left, res.src_top, res.src_right, res.src_bottom,
              res.dst_left, res.dst_top, res.dst_right, res.dst_bottom};
      if (got.visible)
        n_visible++;
      if (expected_clips.size() == 0) begin
        n_errors++;
        if (n_errors <= 10)
          $display("ERROR: result with no command outstanding: %s", show_clip(got));
      end else begin
        want = expected_clips.pop_front();
        if (got !== want) begin
          n_errors++;
          if (n_errors <= 10) begin
            $display("ERROR: clip mismatch at %0t", $realtime);
            $display("  expected %s", show_clip(want));
            $display("  actual   %s", show_clip(got));
          end
        end
      end
    end
  end

  // Hang detection: any handshake on either channel resets the count.
  always @(posedge clk) begin
    if (rst || (cmd.valid && cmd.ready) || (res.valid && res.ready))
      stuck_cycles <= 0;
    else
      stuck_cycles <= stuck_cycles + 1;
    if (stuck_cycles >= STUCK_LIMIT) begin
      $display("ERROR: no handshake for %0d cycles, %0d results outstanding",
               stuck_cycles, expected_clips.size());
      $display("*** FAILED ***");
      $finish;
    end
  end

  initial begin
    logic [31:0] mx;
    // Hold every input at a known value from time zero.
    rst         <= 1'b1;
    cfg_we      <= 1'b0;
    cfg_index   <= REG_SCREEN_MAX_X;
    cfg_data    <= '0;
    cmd.valid   <= 1'b0;
    cmd.kind    <= KIND_COPY;
    cmd.rect_x0 <= '0;
    cmd.rect_y0 <= '0;
    cmd.rect_x1 <= '0;
    cmd.rect_y1 <= '0;
    cmd.dest_x  <= '0;
    cmd.dest_y  <= '0;
    // Shadow starts from the register reset values.
    max_col = 15'(SCREEN_MAX_X_RST);
    max_row = 15'(SCREEN_MAX_Y_RST);
    clip_on = 1'b0;
    clip_x0 = '0;
    clip_y0 = '0;
    clip_x1 = '0;
    clip_y1 = '0;
    n_settings = 1;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // Directed table under the reset window, then random traffic with a full drain midway.
    for (int i = 0; i < $size(dir_rows); i++)
      push_cmd(dir_rows[i].c, dir_rows[i].typed, dir_rows[i].r);
    run_random(300, 1'b1);

    // Largest screen: all-ones writes keep only 15 bits; enable write with bit 0 clear.
    settle();
    load_config(16'hFFFF, 16'hFFFF, 16'hFFFE, 16'h8000, 16'h7FFF, 16'h7FFF, 16'h8000);
    run_random(200, 1'b0);

    // Smallest screen: a single pixel at the origin.
    settle();
    load_config(16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
    run_random(150, 1'b0);

    // User clip inside a small screen, corners given in reverse order.
    settle();
    load_config(16'd319, 16'd199, 16'd1, 16'd300, 16'd180, 16'd20, 16'd10);
    run_random(300, 1'b1);

    // User clip reaching past the screen on several sides.
    settle();
    load_config(16'd639, 16'd479, 16'd1, -16'sd100, 16'd5000, 16'd5000, 16'd100);
    run_random(200, 1'b0);

    // User clip beside the screen: the window is empty, nothing may be visible.
    // Follow with a write to the unused index, which must not reopen it.
    settle();
    load_config(16'd639, 16'd479, 16'hFFFF, 16'd700, 16'd0, 16'd800, 16'd100);
    @(posedge clk);
    write_reg(REG_UNUSED, 16'h8000);
    cfg_we <= 1'b0;
    run_random(100, 1'b0);

    // Random settings; one stretch with no idling on either side.
    for (int p = 0; p < 4; p++) begin
      settle();
      no_idle = (p == 1);
      mx = (p == 3) ? $urandom : $urandom_range(0, 1023);
      load_config(mx[W-1:0], 16'($urandom_range(0, 767)), 16'($urandom),
                  16'(int'($urandom_range(0, 1400)) - 200),
                  16'(int'($urandom_range(0, 1000)) - 200),
                  16'(int'($urandom_range(0, 1400)) - 200),
                  16'(int'($urandom_range(0, 1000)) - 200));
      run_random(150, p == 2);
    end
    no_idle = 1'b0;

    // Wait out every owed result and a little more for strays.
    settle();
    repeat (LATENCY * 4) @(posedge clk);

    $display("Ran %0d commands (%0d copies, %0d fills) over %0d clip settings.",
             n_items, n_copies, n_items - n_copies, n_settings);
    $display("%0d results were visible; %0d mismatches found.", n_visible, n_errors);
    if (n_errors == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

endmodule
